// ===== rtl/core/sss_pkg.sv =====
// Shared definitions for the sample stream statistics core.
// Holds default widths and the control bundle between the front end and the accumulator.
// No dependencies.
package sss_pkg;

    localparam int ValueBitsDef = 16;
    localparam int TimeBitsDef  = 32;
    localparam int AccBitsDef   = 48;
    localparam int CountBits    = 32;

    typedef struct packed {
        logic restart;
        logic pair;
    } sss_ctl_t;

endpackage

// ===== rtl/core/sample_stream_statistics_core.sv =====
// Top level of the sample stream statistics core.
// Pairs each sample with the previous one, forms products, and feeds sss_accum.
// Depends on sss_pkg and sss_accum.
//
// Input channel (in_valid/in_ready) carries one transaction per sample or restart:
// func selects sample (0) or restart (1); sample_time, sample_value and sample_valid
// describe the sample. Output channel (out_valid/out_ready) returns one transaction
// per input transaction holding all statistics after that item.
// An accepted transaction reaches out_valid through three registers:
// a pairing register (time gap and value change), a product register (the two
// multipliers), and the statistics registers, which are also the output registers.
// Throughput is one transaction per cycle while out_ready stays high.
// When the receiver stalls, the output holds and the pipeline fills; in_ready drops
// once all three stages are occupied.
// Reset clears the previous sample, all statistics and all valid flags; min_abs_change
// resets to all ones and min_value to the largest positive value. A restart
// transaction clears the previous sample and all statistics the same way, in stream order.
module sample_stream_statistics_core
    import sss_pkg::*;
#(
    parameter int VALUE_BITS = ValueBitsDef,
    parameter int TIME_BITS  = TimeBitsDef,
    parameter int ACC_BITS   = AccBitsDef
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         func,
    input  logic        [TIME_BITS-1:0]  sample_time,
    input  logic signed [VALUE_BITS-1:0] sample_value,
    input  logic                         sample_valid,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic        [CountBits-1:0]  sample_count,
    output logic        [ACC_BITS-1:0]   total_time,
    output logic signed [ACC_BITS-1:0]   weighted_sum,
    output logic        [ACC_BITS-1:0]   change_area,
    output logic        [VALUE_BITS-1:0] max_rise,
    output logic signed [VALUE_BITS:0]   max_fall,
    output logic        [VALUE_BITS-1:0] min_abs_change,
    output logic        [VALUE_BITS-2:0] max_value,
    output logic signed [VALUE_BITS-1:0] min_value,
    output logic        [ACC_BITS-1:0]   unchanged_time,
    output logic        [ACC_BITS-1:0]   longest_unchanged,
    output logic        [ACC_BITS-1:0]   longest_changing
);

    localparam int PW = VALUE_BITS + TIME_BITS;
    localparam int WP = VALUE_BITS + TIME_BITS + 1;

    logic                         accept, load_b, load_out;
    logic                         a_vld_reg, b_vld_reg, out_vld_reg;

    logic        [TIME_BITS-1:0]  prev_time_reg;
    logic signed [VALUE_BITS-1:0] prev_value_reg;
    logic                         prev_valid_reg;
    logic                         have_prev_reg;

    logic        [TIME_BITS-1:0]  p_time;
    logic signed [VALUE_BITS-1:0] p_value;
    logic                         p_valid;

    sss_ctl_t                     a_ctl_next, a_ctl_reg, b_ctl_reg;
    logic signed [VALUE_BITS-1:0] a_value_reg, b_value_reg;
    logic signed [VALUE_BITS:0]   a_delta_next, a_delta_reg, b_delta_reg;
    logic        [VALUE_BITS-1:0] a_adelta_next, a_adelta_reg, b_adelta_reg;
    logic        [TIME_BITS-1:0]  a_gap_next, a_gap_reg, b_gap_reg;
    logic signed [TIME_BITS:0]    a_sgap_next, a_sgap_reg;
    logic signed [WP-1:0]         b_wprod_next, b_wprod_reg;
    logic        [PW-1:0]         b_aprod_next, b_aprod_reg;

    assign load_out  = b_vld_reg && (out_ready || !out_vld_reg);
    assign load_b    = a_vld_reg && (!b_vld_reg || load_out);
    assign in_ready  = !a_vld_reg || load_b;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_vld_reg;

    always_comb
    begin
        p_time  = have_prev_reg ? prev_time_reg  : sample_time;
        p_value = have_prev_reg ? prev_value_reg : sample_value;
        p_valid = have_prev_reg ? prev_valid_reg : sample_valid;

        a_sgap_next  = $signed({1'b0, sample_time}) - $signed({1'b0, p_time});
        a_gap_next   = (sample_time >= p_time) ? sample_time - p_time : p_time - sample_time;
        a_delta_next = (VALUE_BITS+1)'(sample_value) - (VALUE_BITS+1)'(p_value);
        a_adelta_next = a_delta_next[VALUE_BITS] ? VALUE_BITS'(-a_delta_next)
                                                 : a_delta_next[VALUE_BITS-1:0];

        a_ctl_next.restart = func;
        a_ctl_next.pair    = !func && sample_valid && p_valid;

        b_wprod_next = WP'(a_value_reg) * WP'(a_sgap_reg);
        b_aprod_next = PW'(a_adelta_reg) * PW'(a_gap_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg      <= 1'b0;
            b_vld_reg      <= 1'b0;
            out_vld_reg    <= 1'b0;
            prev_time_reg  <= '0;
            prev_value_reg <= '0;
            prev_valid_reg <= 1'b0;
            have_prev_reg  <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                a_vld_reg <= in_valid;
            end
            if (!b_vld_reg || load_out)
            begin
                b_vld_reg <= a_vld_reg;
            end
            if (out_ready || !out_vld_reg)
            begin
                out_vld_reg <= b_vld_reg;
            end
            if (accept)
            begin
                if (func)
                begin
                    prev_time_reg  <= '0;
                    prev_value_reg <= '0;
                    prev_valid_reg <= 1'b0;
                    have_prev_reg  <= 1'b0;
                end
                else
                begin
                    prev_time_reg  <= sample_time;
                    prev_value_reg <= sample_value;
                    prev_valid_reg <= sample_valid;
                    have_prev_reg  <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_ctl_reg    <= a_ctl_next;
            a_value_reg  <= sample_value;
            a_delta_reg  <= a_delta_next;
            a_adelta_reg <= a_adelta_next;
            a_gap_reg    <= a_gap_next;
            a_sgap_reg   <= a_sgap_next;
        end
        if (load_b)
        begin
            b_ctl_reg    <= a_ctl_reg;
            b_value_reg  <= a_value_reg;
            b_delta_reg  <= a_delta_reg;
            b_adelta_reg <= a_adelta_reg;
            b_gap_reg    <= a_gap_reg;
            b_wprod_reg  <= b_wprod_next;
            b_aprod_reg  <= b_aprod_next;
        end
    end

    sss_accum #(
        .VALUE_BITS (VALUE_BITS),
        .TIME_BITS  (TIME_BITS),
        .ACC_BITS   (ACC_BITS)
    ) u_accum (
        .clk               (clk),
        .rst_n             (rst_n),
        .load              (load_out),
        .ctl               (b_ctl_reg),
        .value             (b_value_reg),
        .delta             (b_delta_reg),
        .adelta            (b_adelta_reg),
        .gap               (b_gap_reg),
        .wprod             (b_wprod_reg),
        .aprod             (b_aprod_reg),
        .sample_count      (sample_count),
        .total_time        (total_time),
        .weighted_sum      (weighted_sum),
        .change_area       (change_area),
        .max_rise          (max_rise),
        .max_fall          (max_fall),
        .min_abs_change    (min_abs_change),
        .max_value         (max_value),
        .min_value         (min_value),
        .unchanged_time    (unchanged_time),
        .longest_unchanged (longest_unchanged),
        .longest_changing  (longest_changing)
    );

    a_pair_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        a_vld_reg && !load_b |=> a_vld_reg && $stable(a_gap_reg) && $stable(a_delta_reg))
        else $error("pairing stage lost or changed a stalled transaction");

    a_prod_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        b_vld_reg && !load_out |=> b_vld_reg && $stable(b_wprod_reg) && $stable(b_aprod_reg))
        else $error("product stage lost or changed a stalled transaction");

    a_restart_drops_prev: assert property (@(posedge clk) disable iff (!rst_n)
        accept && func |=> !have_prev_reg && !prev_valid_reg)
        else $error("restart did not drop the previous sample");

endmodule

// ===== rtl/core/sss_accum.sv =====
// Statistics accumulator of the sample stream statistics core.
// Holds every running statistic, updates them from one registered pair per load, and clears them on a restart.
// Depends on sss_pkg.
module sss_accum
    import sss_pkg::*;
#(
    parameter int VALUE_BITS = ValueBitsDef,
    parameter int TIME_BITS  = TimeBitsDef,
    parameter int ACC_BITS   = AccBitsDef
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                load,
    input  sss_ctl_t                            ctl,
    input  logic signed [VALUE_BITS-1:0]        value,
    input  logic signed [VALUE_BITS:0]          delta,
    input  logic        [VALUE_BITS-1:0]        adelta,
    input  logic        [TIME_BITS-1:0]         gap,
    input  logic signed [VALUE_BITS+TIME_BITS:0] wprod,
    input  logic        [VALUE_BITS+TIME_BITS-1:0] aprod,
    output logic        [CountBits-1:0]         sample_count,
    output logic        [ACC_BITS-1:0]          total_time,
    output logic signed [ACC_BITS-1:0]          weighted_sum,
    output logic        [ACC_BITS-1:0]          change_area,
    output logic        [VALUE_BITS-1:0]        max_rise,
    output logic signed [VALUE_BITS:0]          max_fall,
    output logic        [VALUE_BITS-1:0]        min_abs_change,
    output logic        [VALUE_BITS-2:0]        max_value,
    output logic signed [VALUE_BITS-1:0]        min_value,
    output logic        [ACC_BITS-1:0]          unchanged_time,
    output logic        [ACC_BITS-1:0]          longest_unchanged,
    output logic        [ACC_BITS-1:0]          longest_changing
);

    localparam int GW = ((TIME_BITS > ACC_BITS) ? TIME_BITS : ACC_BITS) + 1;
    localparam int PW = VALUE_BITS + TIME_BITS;
    localparam int AS = ((PW > ACC_BITS) ? PW : ACC_BITS) + 1;
    localparam int WP = VALUE_BITS + TIME_BITS + 1;
    localparam int WS = ((WP > ACC_BITS) ? WP : ACC_BITS) + 1;
    localparam logic signed [WS-1:0] WMAX = WS'({1'b0, {(ACC_BITS-1){1'b1}}});
    localparam logic signed [WS-1:0] WMIN = -WMAX - WS'(1);
    localparam logic signed [VALUE_BITS-1:0] FLOOR_INIT = {1'b0, {(VALUE_BITS-1){1'b1}}};

    logic        [CountBits-1:0]  count_reg, count_next;
    logic        [ACC_BITS-1:0]   time_reg, time_next;
    logic signed [ACC_BITS-1:0]   weighted_reg, weighted_next;
    logic        [ACC_BITS-1:0]   area_reg, area_next;
    logic        [VALUE_BITS-1:0] rise_reg, rise_next;
    logic signed [VALUE_BITS:0]   fall_reg, fall_next;
    logic        [VALUE_BITS-1:0] least_reg, least_next;
    logic        [VALUE_BITS-2:0] peak_reg, peak_next;
    logic signed [VALUE_BITS-1:0] floor_reg, floor_next;
    logic        [ACC_BITS-1:0]   still_reg, still_next;
    logic        [ACC_BITS-1:0]   still_run_reg, still_run_next;
    logic        [ACC_BITS-1:0]   moving_run_reg, moving_run_next;
    logic        [ACC_BITS-1:0]   still_best_reg, still_best_next;
    logic        [ACC_BITS-1:0]   moving_best_reg, moving_best_next;

    logic        [GW-1:0] time_sum, still_sum, srun_sum, mrun_sum;
    logic        [AS-1:0] area_sum;
    logic signed [WS-1:0] w_sum;
    logic        [ACC_BITS-1:0] time_sat, still_sat, srun_sat, mrun_sat, area_sat;
    logic signed [ACC_BITS-1:0] w_sat;
    logic                       unchanged;

    always_comb
    begin
        time_sum  = GW'(time_reg) + GW'(gap);
        still_sum = GW'(still_reg) + GW'(gap);
        srun_sum  = GW'(still_run_reg) + GW'(gap);
        mrun_sum  = GW'(moving_run_reg) + GW'(gap);
        area_sum  = AS'(area_reg) + AS'(aprod);
        w_sum     = WS'(weighted_reg) + WS'(wprod);

        time_sat  = (|time_sum[GW-1:ACC_BITS])  ? '1 : time_sum[ACC_BITS-1:0];
        still_sat = (|still_sum[GW-1:ACC_BITS]) ? '1 : still_sum[ACC_BITS-1:0];
        srun_sat  = (|srun_sum[GW-1:ACC_BITS])  ? '1 : srun_sum[ACC_BITS-1:0];
        mrun_sat  = (|mrun_sum[GW-1:ACC_BITS])  ? '1 : mrun_sum[ACC_BITS-1:0];
        area_sat  = (|area_sum[AS-1:ACC_BITS])  ? '1 : area_sum[ACC_BITS-1:0];
        if (w_sum > WMAX)
        begin
            w_sat = {1'b0, {(ACC_BITS-1){1'b1}}};
        end
        else if (w_sum < WMIN)
        begin
            w_sat = {1'b1, {(ACC_BITS-1){1'b0}}};
        end
        else
        begin
            w_sat = w_sum[ACC_BITS-1:0];
        end

        unchanged = (delta == '0);

        count_next       = count_reg;
        time_next        = time_reg;
        weighted_next    = weighted_reg;
        area_next        = area_reg;
        rise_next        = rise_reg;
        fall_next        = fall_reg;
        least_next       = least_reg;
        peak_next        = peak_reg;
        floor_next       = floor_reg;
        still_next       = still_reg;
        still_run_next   = still_run_reg;
        moving_run_next  = moving_run_reg;
        still_best_next  = still_best_reg;
        moving_best_next = moving_best_reg;

        if (ctl.restart)
        begin
            count_next       = '0;
            time_next        = '0;
            weighted_next    = '0;
            area_next        = '0;
            rise_next        = '0;
            fall_next        = '0;
            least_next       = '1;
            peak_next        = '0;
            floor_next       = FLOOR_INIT;
            still_next       = '0;
            still_run_next   = '0;
            moving_run_next  = '0;
            still_best_next  = '0;
            moving_best_next = '0;
        end
        else if (ctl.pair)
        begin
            count_next    = (&count_reg) ? count_reg : count_reg + CountBits'(1);
            time_next     = time_sat;
            weighted_next = w_sat;
            area_next     = area_sat;
            if (delta > $signed({1'b0, rise_reg}))
            begin
                rise_next = delta[VALUE_BITS-1:0];
            end
            if (delta < fall_reg)
            begin
                fall_next = delta;
            end
            if (adelta < least_reg)
            begin
                least_next = adelta;
            end
            if (value > $signed({1'b0, peak_reg}))
            begin
                peak_next = value[VALUE_BITS-2:0];
            end
            if (value < floor_reg)
            begin
                floor_next = value;
            end
            if (unchanged)
            begin
                still_next      = still_sat;
                still_run_next  = srun_sat;
                moving_run_next = '0;
                if (srun_sat > still_best_reg)
                begin
                    still_best_next = srun_sat;
                end
            end
            else
            begin
                moving_run_next = mrun_sat;
                still_run_next  = '0;
                if (mrun_sat > moving_best_reg)
                begin
                    moving_best_next = mrun_sat;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg       <= '0;
            time_reg        <= '0;
            weighted_reg    <= '0;
            area_reg        <= '0;
            rise_reg        <= '0;
            fall_reg        <= '0;
            least_reg       <= '1;
            peak_reg        <= '0;
            floor_reg       <= FLOOR_INIT;
            still_reg       <= '0;
            still_run_reg   <= '0;
            moving_run_reg  <= '0;
            still_best_reg  <= '0;
            moving_best_reg <= '0;
        end
        else if (load)
        begin
            count_reg       <= count_next;
            time_reg        <= time_next;
            weighted_reg    <= weighted_next;
            area_reg        <= area_next;
            rise_reg        <= rise_next;
            fall_reg        <= fall_next;
            least_reg       <= least_next;
            peak_reg        <= peak_next;
            floor_reg       <= floor_next;
            still_reg       <= still_next;
            still_run_reg   <= still_run_next;
            moving_run_reg  <= moving_run_next;
            still_best_reg  <= still_best_next;
            moving_best_reg <= moving_best_next;
        end
    end

    assign sample_count      = count_reg;
    assign total_time        = time_reg;
    assign weighted_sum      = weighted_reg;
    assign change_area       = area_reg;
    assign max_rise          = rise_reg;
    assign max_fall          = fall_reg;
    assign min_abs_change    = least_reg;
    assign max_value         = peak_reg;
    assign min_value         = floor_reg;
    assign unchanged_time    = still_reg;
    assign longest_unchanged = still_best_reg;
    assign longest_changing  = moving_best_reg;

    a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
        load && ctl.restart |=> sample_count == '0 && total_time == '0 && min_abs_change == '1)
        else $error("restart did not clear statistics");

    a_runs_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        still_run_reg <= still_best_reg && moving_run_reg <= moving_best_reg)
        else $error("current run exceeds its recorded longest run");

    a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        load && !ctl.restart |=> sample_count >= $past(sample_count))
        else $error("pair count decreased without restart");

endmodule
